[rtl/core/wfpd_pkg.sv]
// ----------------------------------------------------------------------------
// wfpd_pkg
// Shared widths, codes and control types of the wear filter peer-deviation
// block.
// ----------------------------------------------------------------------------
package wfpd_pkg;

  localparam int MAX_SENSORS = 16;
  localparam int FRAC_BITS   = 16;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int SAMPLE_W   = 16;
  localparam int MASK_W     = 16;
  localparam int DEV_W      = 17;
  localparam int STATUS_W   = 2;
  localparam int SCOUNT_W   = 5;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 16;

  localparam int STORE_W    = SAMPLE_W + FRAC_BITS;
  localparam int PCNT_W     = 4;
  localparam int CCNT_W     = 2;
  localparam int PSUM_W     = STORE_W + PCNT_W;
  localparam int NUM_W      = PSUM_W + 4;
  localparam int DEN_W      = 5;
  localparam int QUO_W      = NUM_W - FRAC_BITS;
  localparam int DIV_STEPS  = QUO_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int PROD_W     = STORE_W + 1 + GAIN_W + 1;

  localparam logic [SCOUNT_W-1:0] RST_SENSOR_COUNT   = SCOUNT_W'(16);
  localparam logic [GAIN_W-1:0]   RST_FILTER_GAIN    = GAIN_W'(6554);
  localparam logic [LIMIT_W-1:0]  RST_ALARM_LIMIT    = LIMIT_W'(50);
  localparam logic [LIMIT_W-1:0]  RST_SLOWDOWN_LIMIT = LIMIT_W'(100);

  localparam logic [DEV_W-1:0] DEV_POS_MAX = DEV_W'(65535);
  localparam logic [DEV_W-1:0] DEV_NEG_MAG = DEV_W'(65536);

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_SENSOR   = 2'd1,
    CMD_CYLINDER = 2'd2
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_NORMAL   = 2'd0,
    STAT_ALARM    = 2'd1,
    STAT_SLOWDOWN = 2'd2
  } status_e_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SENSOR_COUNT   = 2'd0,
    CFG_FILTER_GAIN    = 2'd1,
    CFG_ALARM_LIMIT    = 2'd2,
    CFG_SLOWDOWN_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SRD   = 10'b00_0000_0010,
    ST_SMUL  = 10'b00_0000_0100,
    ST_SWR   = 10'b00_0000_1000,
    ST_WALK  = 10'b00_0001_0000,
    ST_DRAIN = 10'b00_0010_0000,
    ST_PREP  = 10'b00_0100_0000,
    ST_ROUND = 10'b00_1000_0000,
    ST_DIV   = 10'b01_0000_0000,
    ST_EMIT  = 10'b10_0000_0000
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic rd_item;
    logic walk;
    logic sample_mul;
    logic sample_wr;
    logic prep;
    logic round;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
  } dp_stat_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] deviation;
    logic [STATUS_W-1:0]     status;
    logic                    degenerate;
  } result_t;

endpackage

[rtl/core/wfpd_if.sv]
// ----------------------------------------------------------------------------
// wfpd_if
// Valid/ready channels of the wear filter: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface wfpd_in_if import wfpd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [IDX_W-1:0]           index;
  logic signed [SAMPLE_W-1:0] sample;
  logic [MASK_W-1:0]          valid_mask;

  modport source (output valid, command, index, sample, valid_mask, input ready);
  modport sink   (input valid, command, index, sample, valid_mask, output ready);
endinterface

interface wfpd_out_if import wfpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DEV_W-1:0] deviation;
  logic [STATUS_W-1:0]     status;
  logic                    degenerate;

  modport source (output valid, deviation, status, degenerate, input ready);
  modport sink   (input valid, deviation, status, degenerate, output ready);
endinterface

[rtl/core/wfpd_ctrl.sv]
// ----------------------------------------------------------------------------
// wfpd_ctrl
// Sequencer: accepts a beat, steps the datapath through sample update or
// store walk, mean, rounding divide and result hand-off.
// ----------------------------------------------------------------------------
module wfpd_ctrl import wfpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  logic             slot_free,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_command)
            CMD_SAMPLE:   state_nxt = ST_SRD;
            CMD_SENSOR:   state_nxt = ST_WALK;
            CMD_CYLINDER: state_nxt = ST_WALK;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SRD: begin
        cmd.rd_item = 1'b1;
        state_nxt   = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.sample_mul = 1'b1;
        state_nxt      = ST_SWR;
      end
      ST_SWR: begin
        cmd.sample_wr = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/wfpd_datapath.sv]
// ----------------------------------------------------------------------------
// wfpd_datapath
// Filtered store, sample filter update, peer/target accumulation, deviation
// numerator and rounding divider, saturation and classification.
// ----------------------------------------------------------------------------
module wfpd_datapath import wfpd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [IDX_W-1:0]           in_index,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [MASK_W-1:0]          in_valid_mask,
  input  logic [SCOUNT_W-1:0]        sensor_count,
  input  logic [GAIN_W-1:0]          filter_gain,
  input  logic [LIMIT_W-1:0]         alarm_limit,
  input  logic [LIMIT_W-1:0]         slowdown_limit,
  output dp_stat_t                   stat,
  output result_t                    res
);

  // item
  logic [CMD_W-1:0]           cmd_r;
  logic [IDX_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [MASK_W-1:0]          mask_r;

  // store
  logic signed [STORE_W-1:0] mem [MAX_SENSORS];
  logic [MAX_SENSORS-1:0]    vld_r;
  logic signed [STORE_W-1:0] rd_data_r;
  logic [IDX_W-1:0]          rd_j_r;
  logic [IDX_W-1:0]          rd_addr;
  logic                      acc_en_r;
  logic [IDX_W-1:0]          wj_r;

  // sample update
  logic signed [STORE_W:0]   tgt_ext;
  logic signed [STORE_W:0]   old_ext;
  logic signed [STORE_W:0]   diff;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  step_full;
  logic signed [STORE_W-1:0] new_val;

  // accumulation
  logic signed [STORE_W:0]  cyl_sum_r;
  logic [CCNT_W-1:0]        cyl_cnt_r;
  logic signed [PSUM_W-1:0] peer_sum_r;
  logic [PCNT_W-1:0]        peer_cnt_r;
  logic [SCOUNT_W-1:0]      n_live;
  logic [SCOUNT_W-1:0]      j5;
  logic [SCOUNT_W-1:0]      fore5;
  logic [SCOUNT_W-1:0]      aft5;
  logic                     is_sensor;
  logic                     is_tgt;
  logic                     j_valid;
  logic                     tgt_add;
  logic                     peer_add;

  // numerator and divider
  logic signed [NUM_W-1:0] cyl_ext;
  logic signed [NUM_W-1:0] peer_ext;
  logic signed [NUM_W-1:0] lhs;
  logic signed [NUM_W-1:0] rhs;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_nxt;
  logic [DEN_W-1:0]        den_r;
  logic                    range_bad;
  logic                    degen_r;
  logic                    neg_r;
  logic [NUM_W-1:0]        mag;
  logic [NUM_W-1:0]        biased;
  logic [QUO_W-1:0]        quo_r;
  logic [DEN_W-1:0]        rem_r;
  logic [STEP_W-1:0]       step_r;
  logic [DEN_W:0]          dd;
  logic [DEN_W:0]          r1;
  logic [DEN_W:0]          r1s;
  logic [DEN_W:0]          r2;
  logic [DEN_W:0]          r2s;
  logic                    ge1;
  logic                    ge2;

  // result
  logic             sat;
  logic [DEV_W-1:0] dev_mag;
  logic [DEV_W-1:0] dev_val;

  assign rd_addr = cmd.walk ? wj_r : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      idx_r    <= in_index;
      sample_r <= in_sample;
      mask_r   <= in_valid_mask;
    end
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      mem[idx_r] <= new_val;
    end
    if (cmd.walk || cmd.rd_item) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
      rd_j_r    <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.walk;
      if (cmd.sample_wr) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // sample filter: old + floor((new - old) * gain / 2^16)
  assign tgt_ext   = {sample_r[SAMPLE_W-1], sample_r, {FRAC_BITS{1'b0}}};
  assign old_ext   = {rd_data_r[STORE_W-1], rd_data_r};
  assign diff      = tgt_ext - old_ext;
  assign step_full = prod_r >>> GAIN_W;
  assign new_val   = rd_data_r + step_full[STORE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sample_mul) begin
      prod_r <= PROD_W'(diff) * PROD_W'($signed({1'b0, filter_gain}));
    end
  end

  // walk and accumulate
  assign n_live    = (sensor_count > SCOUNT_W'(MAX_SENSORS)) ?
                     SCOUNT_W'(MAX_SENSORS) : sensor_count;
  assign j5        = {1'b0, rd_j_r};
  assign fore5     = {idx_r, 1'b0};
  assign aft5      = {idx_r, 1'b1};
  assign is_sensor = (cmd_r == CMD_SENSOR);
  assign is_tgt    = is_sensor ? (j5 == {1'b0, idx_r}) : ((j5 == fore5) || (j5 == aft5));
  assign j_valid   = mask_r[rd_j_r];
  assign tgt_add   = is_tgt && (is_sensor || j_valid);
  assign peer_add  = (j5 < n_live) && j_valid && !is_tgt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wj_r       <= '0;
      cyl_sum_r  <= '0;
      cyl_cnt_r  <= '0;
      peer_sum_r <= '0;
      peer_cnt_r <= '0;
    end else begin
      if (cmd.walk) begin
        wj_r <= wj_r + 1'b1;
      end
      if (acc_en_r && tgt_add) begin
        cyl_sum_r <= cyl_sum_r + (STORE_W+1)'(rd_data_r);
        cyl_cnt_r <= cyl_cnt_r + 1'b1;
      end
      if (acc_en_r && peer_add) begin
        peer_sum_r <= peer_sum_r + PSUM_W'(rd_data_r);
        peer_cnt_r <= peer_cnt_r + 1'b1;
      end
    end
  end

  assign stat.walk_last = (wj_r == IDX_W'(MAX_SENSORS - 1));

  // numerator: target_sum * peers - peer_sum * targets
  assign cyl_ext   = NUM_W'(cyl_sum_r);
  assign peer_ext  = NUM_W'(peer_sum_r);
  assign lhs       = cyl_ext * NUM_W'($signed({1'b0, peer_cnt_r}));
  assign rhs       = (cyl_cnt_r == CCNT_W'(2)) ? (peer_ext <<< 1) : peer_ext;
  assign den_nxt   = (cyl_cnt_r == CCNT_W'(2)) ? {peer_cnt_r, 1'b0} : {1'b0, peer_cnt_r};
  assign range_bad = is_sensor ? ({1'b0, idx_r} >= n_live) : (aft5 >= n_live);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_r   <= lhs - rhs;
      den_r   <= den_nxt;
      degen_r <= range_bad || (cyl_cnt_r == '0) || (peer_cnt_r == '0);
    end
  end

  // round half away: floor((|num| + den*2^(F-1)) / 2^F) / den
  assign mag    = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign biased = mag + (NUM_W'(den_r) << (FRAC_BITS - 1));

  // two quotient bits per cycle
  assign dd  = {1'b0, den_r};
  assign r1  = {rem_r, quo_r[QUO_W-1]};
  assign ge1 = (r1 >= dd);
  assign r1s = ge1 ? (r1 - dd) : r1;
  assign r2  = {r1s[DEN_W-1:0], quo_r[QUO_W-2]};
  assign ge2 = (r2 >= dd);
  assign r2s = ge2 ? (r2 - dd) : r2;

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      neg_r  <= num_r[NUM_W-1];
      quo_r  <= biased[NUM_W-1:FRAC_BITS];
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[QUO_W-3:0], ge1, ge2};
      rem_r  <= r2s[DEN_W-1:0];
      step_r <= step_r + 1'b1;
    end
  end

  assign stat.div_last = (step_r == STEP_W'(DIV_STEPS - 1));

  // saturate and classify
  always_comb begin
    if (neg_r) begin
      sat     = (quo_r > QUO_W'(DEV_NEG_MAG));
      dev_mag = sat ? DEV_NEG_MAG : quo_r[DEV_W-1:0];
      dev_val = DEV_W'(-dev_mag);
    end else begin
      sat     = (quo_r > QUO_W'(DEV_POS_MAX));
      dev_mag = sat ? DEV_POS_MAX : quo_r[DEV_W-1:0];
      dev_val = dev_mag;
    end
    if (degen_r) begin
      res.deviation  = '0;
      res.status     = STAT_NORMAL;
      res.degenerate = 1'b1;
    end else begin
      res.deviation  = $signed(dev_val);
      res.degenerate = 1'b0;
      if (dev_mag >= {1'b0, slowdown_limit}) begin
        res.status = STAT_SLOWDOWN;
      end else if (dev_mag >= {1'b0, alarm_limit}) begin
        res.status = STAT_ALARM;
      end else begin
        res.status = STAT_NORMAL;
      end
    end
  end

endmodule

[rtl/core/wear_filter_peer_deviation.sv]
// ----------------------------------------------------------------------------
// wear_filter_peer_deviation
// Per-sensor filtered wear with peer-deviation queries.
//
// in_bus carries command beats: a sample beat updates one sensor's filtered
// value and returns nothing; a sensor or cylinder query beat returns one
// beat on out_bus with the rounded deviation, its status and a degenerate
// flag. Command code 3 is dropped without a result.
// cfg_we/cfg_index/cfg_wdata write the four settings; the user must do so
// only while the block is idle, which the block itself does not enforce.
// A query beat walks the store through its single read port, forms and
// biases the numerator, runs the rounding divider at two quotient bits a
// cycle and loads the output register. The next beat is taken once the
// previous one is through; a result parked in the output register does not
// hold off the next accept, only the next result.
// Reset clears the store (every sensor reads zero), restores the default
// settings and empties the output register. While out_bus is stalled a
// finished query holds in its final step until the register frees up.
// ----------------------------------------------------------------------------
module wear_filter_peer_deviation import wfpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wfpd_in_if.sink           in_bus,
  wfpd_out_if.source        out_bus,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [SCOUNT_W-1:0] sensor_count_r;
  logic [GAIN_W-1:0]   filter_gain_r;
  logic [LIMIT_W-1:0]  alarm_limit_r;
  logic [LIMIT_W-1:0]  slowdown_limit_r;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  result_t  out_r;
  logic     out_valid_r;
  logic     slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_count_r   <= RST_SENSOR_COUNT;
      filter_gain_r    <= RST_FILTER_GAIN;
      alarm_limit_r    <= RST_ALARM_LIMIT;
      slowdown_limit_r <= RST_SLOWDOWN_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSOR_COUNT:   sensor_count_r   <= cfg_wdata[SCOUNT_W-1:0];
        CFG_FILTER_GAIN:    filter_gain_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_ALARM_LIMIT:    alarm_limit_r    <= cfg_wdata[LIMIT_W-1:0];
        CFG_SLOWDOWN_LIMIT: slowdown_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid_r || out_bus.ready;

  wfpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_command (in_bus.command),
    .in_ready   (in_bus.ready),
    .slot_free  (slot_free),
    .stat       (stat),
    .cmd        (cmd)
  );

  wfpd_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_command     (in_bus.command),
    .in_index       (in_bus.index),
    .in_sample      (in_bus.sample),
    .in_valid_mask  (in_bus.valid_mask),
    .sensor_count   (sensor_count_r),
    .filter_gain    (filter_gain_r),
    .alarm_limit    (alarm_limit_r),
    .slowdown_limit (slowdown_limit_r),
    .stat           (stat),
    .res            (res)
  );

  // output register: load on emit, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.deviation  = out_r.deviation;
  assign out_bus.status     = out_r.status;
  assign out_bus.degenerate = out_r.degenerate;

endmodule
